FILE: hdl/multidrop_packet_receiver_assert.svh
// assertion macros used by the checker file
`ifndef MULTIDROP_PACKET_RECEIVER_ASSERT_SVH
`define MULTIDROP_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define MPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/mpr_pkg.sv
package mpr_pkg;

    // framing characters
    localparam logic [7:0] SOH = 8'h01;
    localparam logic [7:0] STX = 8'h02;
    localparam logic [7:0] ETX = 8'h03;
    localparam logic [7:0] EOT = 8'h04;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_STATION       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_STATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH        = 2'd2;

    // result kinds
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_GOOD    = 2'd2,
        KIND_BAD     = 2'd3
    } t_kind;

    // six-byte header window, entry 0 is the oldest byte
    typedef logic [7:0] t_win [6];

    // header check result
    typedef struct packed {
        logic       match;    // framing of a header seen
        logic       accept;   // header addressed to us and length allowed
        logic [7:0] sender;
        logic [7:0] command;
        logic [7:0] length;
        logic [7:0] sum;
    } t_hdr;

endpackage

FILE: hdl/mpr_hdr_check.sv
module mpr_hdr_check (
    input  mpr_pkg::t_win i_window,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_own_station,
    input  logic [7:0]    i_broadcast_station,
    input  logic [7:0]    i_max_length,
    output mpr_pkg::t_hdr o_hdr
);
    import mpr_pkg::*;

    logic [7:0] dest;
    logic       dest_ok;

    // i_window is the window before the shift; the new byte arrives on i_rx_byte
    assign dest = i_window[2];

    assign dest_ok = (dest == i_own_station) || (dest == i_broadcast_station);

    always_comb begin
        o_hdr.match   = (i_window[1] == SOH) && (i_rx_byte == STX)
                        && (i_window[2] != i_window[3]);
        o_hdr.accept  = o_hdr.match && dest_ok && (i_window[5] <= i_max_length);
        o_hdr.sender  = i_window[3];
        o_hdr.command = i_window[4];
        o_hdr.length  = i_window[5];
        o_hdr.sum     = i_window[2] + i_window[3] + i_window[4] + i_window[5];
    end

endmodule

FILE: hdl/multidrop_packet_receiver.sv
// channel  | direction | handshake            | word
// ---------+-----------+----------------------+------------------------------------
// rx       | in        | i_valid / o_ready    | i_rx_byte
// result   | out       | o_valid / i_ready    | o_kind, o_sender, o_command,
//          |           |                      | o_length, o_data_byte, o_last
// config   | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// one rx word per cycle while o_ready is high; its result (if any) is on the output in the next cycle
// all parsing is combinational compare/shift/8-bit add logic between the input and the result register
// o_ready stays high while the result register is empty or being drained
// reset (synchronous, active low) clears window, phase, counters and stations; max length to 8'hFF
// a stalled result holds and blocks new words only while the register is full
module multidrop_packet_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_sender,
    output logic [7:0] o_command,
    output logic [7:0] o_length,
    output logic [7:0] o_data_byte,
    output logic       o_last
);
    import mpr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_PAYLOAD  = 3'd1,
        PH_ETX      = 3'd2,
        PH_CHECKSUM = 3'd3,
        PH_EOT      = 3'd4
    } t_phase;

    // configuration
    logic [7:0] r_own_station;
    logic [7:0] r_broadcast_station;
    logic [7:0] r_max_length;

    // parser state
    t_win       r_window, n_window;
    t_phase     r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_exp_len, n_exp_len;
    logic [7:0] r_run_sum, n_run_sum;
    logic [7:0] r_rcv_sum, n_rcv_sum;
    logic [7:0] r_sender, n_sender;
    logic [7:0] r_command, n_command;

    // result register
    logic       r_out_valid;
    t_kind      r_kind;
    logic [7:0] r_out_sender, r_out_command, r_out_length, r_out_data;

    logic       res_valid;
    t_kind      res_kind;
    logic [7:0] res_data;
    logic [7:0] count_inc;
    logic       in_acc;
    t_hdr       hdr;

    assign o_ready = !r_out_valid || i_ready;
    assign in_acc  = i_valid && o_ready;

    mpr_hdr_check u_hdr (
        .i_window            (r_window),
        .i_rx_byte           (i_rx_byte),
        .i_own_station       (r_own_station),
        .i_broadcast_station (r_broadcast_station),
        .i_max_length        (r_max_length),
        .o_hdr               (hdr)
    );

    assign count_inc = r_count + 8'd1;

    // next state and result for the incoming word
    always_comb begin
        n_window  = r_window;
        n_phase   = r_phase;
        n_count   = r_count;
        n_exp_len = r_exp_len;
        n_run_sum = r_run_sum;
        n_rcv_sum = r_rcv_sum;
        n_sender  = r_sender;
        n_command = r_command;
        res_valid = 1'b0;
        res_kind  = KIND_HEADER;
        res_data  = 8'd0;
        unique case (r_phase)
            PH_HUNT: begin
                for (int i = 0; i < 5; i++) begin
                    n_window[i] = r_window[i+1];
                end
                n_window[5] = i_rx_byte;
                if (hdr.accept) begin
                    n_sender  = hdr.sender;
                    n_command = hdr.command;
                    n_exp_len = hdr.length;
                    n_run_sum = hdr.sum;
                    n_count   = 8'd0;
                    n_phase   = (hdr.length == 8'd0) ? PH_ETX : PH_PAYLOAD;
                    res_valid = 1'b1;
                    res_kind  = KIND_HEADER;
                end else if (hdr.match) begin
                    n_count   = 8'd0;
                    n_exp_len = 8'd0;
                    n_run_sum = 8'd0;
                    n_rcv_sum = 8'd0;
                end
            end
            PH_PAYLOAD: begin
                n_run_sum = r_run_sum + i_rx_byte;
                n_count   = count_inc;
                if (count_inc >= r_exp_len) begin
                    n_phase = PH_ETX;
                end
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_data  = i_rx_byte;
            end
            PH_ETX: begin
                if (i_rx_byte == ETX) begin
                    n_phase = PH_CHECKSUM;
                end else begin
                    res_valid = 1'b1;
                    res_kind  = KIND_BAD;
                    n_phase   = PH_HUNT;
                    n_count   = 8'd0;
                    n_exp_len = 8'd0;
                    n_run_sum = 8'd0;
                    n_rcv_sum = 8'd0;
                end
            end
            PH_CHECKSUM: begin
                n_rcv_sum = i_rx_byte;
                n_phase   = PH_EOT;
            end
            PH_EOT: begin
                res_valid = 1'b1;
                res_kind  = ((i_rx_byte == EOT) && (r_rcv_sum == r_run_sum))
                            ? KIND_GOOD : KIND_BAD;
                n_phase   = PH_HUNT;
                n_count   = 8'd0;
                n_exp_len = 8'd0;
                n_run_sum = 8'd0;
                n_rcv_sum = 8'd0;
            end
            default: begin
                n_phase   = PH_HUNT;
                n_count   = 8'd0;
                n_exp_len = 8'd0;
                n_run_sum = 8'd0;
                n_rcv_sum = 8'd0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_station       <= 8'd0;
            r_broadcast_station <= 8'd0;
            r_max_length        <= 8'hFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OWN_STATION:       r_own_station       <= i_cfg_data;
                CFG_BROADCAST_STATION: r_broadcast_station <= i_cfg_data;
                CFG_MAX_LENGTH:        r_max_length        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_window[i] <= 8'd0;
            end
            r_phase   <= PH_HUNT;
            r_count   <= 8'd0;
            r_exp_len <= 8'd0;
            r_run_sum <= 8'd0;
            r_rcv_sum <= 8'd0;
            r_sender  <= 8'd0;
            r_command <= 8'd0;
        end else if (in_acc) begin
            r_window  <= n_window;
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_exp_len <= n_exp_len;
            r_run_sum <= n_run_sum;
            r_rcv_sum <= n_rcv_sum;
            r_sender  <= n_sender;
            r_command <= n_command;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload: sender and command as they stand after the word is taken, length from the header
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_kind        <= res_kind;
            r_out_sender  <= n_sender;
            r_out_command <= n_command;
            r_out_length  <= (res_kind == KIND_HEADER) ? n_exp_len : r_exp_len;
            r_out_data    <= res_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_kind      = r_kind;
    assign o_sender    = r_out_sender;
    assign o_command   = r_out_command;
    assign o_length    = r_out_length;
    assign o_data_byte = r_out_data;
    assign o_last      = (r_kind == KIND_GOOD) || (r_kind == KIND_BAD);

endmodule

FILE: hdl/mpr_checker.sv
`include "multidrop_packet_receiver_assert.svh"

module mpr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_kind,
    input logic [7:0] o_sender,
    input logic [7:0] o_command,
    input logic [7:0] o_length,
    input logic [7:0] o_data_byte,
    input logic       o_last
);
    import mpr_pkg::*;

    logic        is_verdict;
    logic        non_payload;
    logic        out_stall;
    logic [34:0] out_word;

    // helper terms over the result port
    assign is_verdict  = (o_kind == KIND_GOOD) || (o_kind == KIND_BAD);
    assign non_payload = o_valid && (o_kind != KIND_PAYLOAD);
    assign out_stall   = o_valid && !i_ready;
    assign out_word    = {o_kind, o_sender, o_command, o_length, o_data_byte, o_last};

    // last flags exactly the verdict words
    `MPR_ASSERT_NOW(a_last_on_verdict, i_clk, i_rst_n, o_valid, o_last == is_verdict)

    // data byte is zero outside payload words
    `MPR_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, non_payload, o_data_byte == 8'd0)

    // input stalls only behind a held result
    `MPR_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, !o_ready, out_stall)

    // a stalled result word holds
    `MPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(out_word))

endmodule

bind multidrop_packet_receiver mpr_checker u_mpr_checker (.*);
